### src/uecho_pkg.sv
`timescale 1ns / 1ps
// Package for the UART echo unit: result word type, phase codes, register indexes.
// No dependencies.
package uecho_pkg;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_BIT_TICKS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CASE_OFFSET = 2'd1;

	localparam logic [15:0] BIT_TICKS_RST   = 16'd48;
	localparam logic [7:0]  CASE_OFFSET_RST = 8'h20;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'b0001,
		PH_START = 4'b0010,
		PH_DATA  = 4'b0100,
		PH_TX    = 4'b1000
	} phase_t;

	typedef struct packed {
		logic       tx_level;
		logic [7:0] rx_byte;
		logic       byte_valid;
		logic       false_start;
		logic       busy_res;
	} res_t;

endpackage

### src/uecho_core.sv
`timescale 1ns / 1ps
// Frame engine of the UART echo unit: receive/transmit state and one-tick step logic.
// Depends on uecho_pkg.
module uecho_core #(
	parameter int DATA_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               rx_level,
	input  logic [15:0]        bit_ticks,
	input  logic [7:0]         case_offset,
	output uecho_pkg::res_t    res
);

	localparam int FRAME_BITS = DATA_BITS + 2;
	localparam int SUB_W      = (DATA_BITS > 8) ? DATA_BITS : 8;

	uecho_pkg::phase_t         phase_q, phase_d;
	logic [15:0]               tick_q, tick_d, tick_inc;
	logic [3:0]                bits_q, bits_d, bits_inc;
	logic [DATA_BITS-1:0]      rx_shift_q, rx_shift_d, rx_next;
	logic [FRAME_BITS-1:0]     tx_shift_q, tx_shift_d;
	logic                      last_rx_q;
	logic [15:0]               period, half;
	logic [SUB_W-1:0]          rx_ext, echo_ext;

	assign period   = (bit_ticks == 16'd0) ? 16'd1 : bit_ticks;
	assign half     = (bit_ticks[15:1] == 15'd0) ? 16'd1 : {1'b0, bit_ticks[15:1]};
	assign tick_inc = tick_q + 16'd1;
	assign bits_inc = bits_q + 4'd1;
	assign rx_next  = {rx_level, rx_shift_q[DATA_BITS-1:1]};
	assign rx_ext   = SUB_W'(rx_next);
	assign echo_ext = rx_ext - SUB_W'(case_offset);

	always_comb begin
		phase_d     = phase_q;
		tick_d      = tick_q;
		bits_d      = bits_q;
		rx_shift_d  = rx_shift_q;
		tx_shift_d  = tx_shift_q;
		res         = '0;
		res.tx_level = 1'b1;
		case (phase_q)
			uecho_pkg::PH_IDLE: begin
				// falling edge opens a frame
				if (last_rx_q && !rx_level) begin
					phase_d = uecho_pkg::PH_START;
					tick_d  = '0;
				end
			end
			uecho_pkg::PH_START: begin
				tick_d = tick_inc;
				if (tick_inc >= half) begin
					tick_d = '0;
					if (rx_level) begin
						res.false_start = 1'b1;
						phase_d         = uecho_pkg::PH_IDLE;
					end else begin
						bits_d     = '0;
						rx_shift_d = '0;
						phase_d    = uecho_pkg::PH_DATA;
					end
				end
			end
			uecho_pkg::PH_DATA: begin
				tick_d = tick_inc;
				if (tick_inc >= period) begin
					tick_d     = '0;
					rx_shift_d = rx_next;
					bits_d     = bits_inc;
					if (bits_inc >= 4'(DATA_BITS)) begin
						res.byte_valid = 1'b1;
						res.rx_byte    = rx_ext[7:0];
						tx_shift_d     = {1'b1, echo_ext[DATA_BITS-1:0], 1'b0};
						bits_d         = '0;
						phase_d        = uecho_pkg::PH_TX;
					end
				end
			end
			uecho_pkg::PH_TX: begin
				res.tx_level = tx_shift_q[0];
				tick_d       = tick_inc;
				if (tick_inc >= period) begin
					tick_d     = '0;
					tx_shift_d = {1'b1, tx_shift_q[FRAME_BITS-1:1]};
					bits_d     = bits_inc;
					if (bits_inc >= 4'(FRAME_BITS)) begin
						bits_d     = '0;
						tx_shift_d = '1;
						phase_d    = uecho_pkg::PH_IDLE;
					end
				end
			end
			default: begin
				phase_d = uecho_pkg::PH_IDLE;
			end
		endcase
		res.busy_res = (phase_d != uecho_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= uecho_pkg::PH_IDLE;
			tick_q     <= '0;
			bits_q     <= '0;
			rx_shift_q <= '0;
			tx_shift_q <= '1;
			last_rx_q  <= 1'b1;
		end else if (step) begin
			phase_q    <= phase_d;
			tick_q     <= tick_d;
			bits_q     <= bits_d;
			rx_shift_q <= rx_shift_d;
			tx_shift_q <= tx_shift_d;
			last_rx_q  <= rx_level;
		end
	end

endmodule

### src/uart_echo_with_offset_unit.sv
`timescale 1ns / 1ps
// Top level of the UART echo unit: handshakes, configuration registers, result register.
// Depends on uecho_pkg and uecho_core.
//
// Half-duplex 8N1 UART echo. Each input word is one sample of the receive
// line; each accepted word yields exactly one result word carrying the
// transmit line level, the received byte with its strobe, a false-start
// flag and a busy flag. A falling edge starts a frame, the start bit is
// rechecked at half a bit period, DATA_BITS data bits are sampled LSB
// first one period apart, and the byte minus case_offset (wrapping) is
// sent back as start bit, data bits and stop bit. Rate: one word per clock
// unless out_ready stalls it; the frame step is combinational from the
// sampled word to the result register, so a word's result appears in the
// next cycle. in_ready is high whenever the result register is empty or
// is being drained in the same cycle. Configuration (index 0 bit_ticks,
// index 1 case_offset) is a plain write port and takes effect at once.
module uart_echo_with_offset_unit #(
	parameter int DATA_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              rx_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              tx_level,
	output logic [7:0]                        rx_byte,
	output logic                              byte_valid,
	output logic                              false_start,
	output logic                              busy_res,
	input  logic                              cfg_we,
	input  logic [uecho_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                       cfg_wdata
);

	logic [15:0]     bit_ticks_q;
	logic [7:0]      case_offset_q;
	logic            out_valid_q;
	uecho_pkg::res_t res_next, res_q;
	logic            take;

	// accept a word while the result register is free or being drained
	assign in_ready = !out_valid_q || out_ready;
	assign take     = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q   <= uecho_pkg::BIT_TICKS_RST;
			case_offset_q <= uecho_pkg::CASE_OFFSET_RST;
		end else if (cfg_we) begin
			if (cfg_index == uecho_pkg::CFG_BIT_TICKS) begin
				bit_ticks_q <= cfg_wdata;
			end
			if (cfg_index == uecho_pkg::CFG_CASE_OFFSET) begin
				case_offset_q <= cfg_wdata[7:0];
			end
		end
	end

	uecho_core #(
		.DATA_BITS(DATA_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (take),
		.rx_level    (rx_level),
		.bit_ticks   (bit_ticks_q),
		.case_offset (case_offset_q),
		.res         (res_next)
	);

	// result register: load on accept, drop valid when taken with nothing new
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign tx_level    = res_q.tx_level;
	assign rx_byte     = res_q.rx_byte;
	assign byte_valid  = res_q.byte_valid;
	assign false_start = res_q.false_start;
	assign busy_res    = res_q.busy_res;

`ifndef SYNTHESIS
	// a received byte always starts transmission, so the frame stays busy
	a_byte_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.byte_valid) |-> res_q.busy_res)
		else $error("byte strobe without busy");

	// a false start returns to idle
	a_fstart_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.false_start) |-> !res_q.busy_res)
		else $error("false start left block busy");

	// the two strobes cannot fire on one tick
	a_strobe_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.byte_valid && res_q.false_start))
		else $error("byte strobe and false start together");

	// a low transmit line only occurs inside a frame
	a_tx_low_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_q.tx_level) |-> res_q.busy_res)
		else $error("transmit line low while idle");

	// an accepted word always produces a pending result next cycle
	a_take_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("accepted word produced no result");
`endif

endmodule
